// ===== sv/mscd_pkg.sv =====
// mscd_pkg: shared types, kind codes and opcode table lookup for the
// sequence command decoder. No dependencies; used by every other file.
package mscd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned KIND_W = 6;
  localparam int unsigned LEN_W  = 3;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned NIB_W  = 4;
  localparam int unsigned CHAN_W = 2;

  localparam logic [CHAN_W-1:0] DRUM_CHAN = 2'd3;

  // opcode range boundaries
  localparam logic [BYTE_W-1:0] OP_LATE_NOTE_LO  = 8'h10;
  localparam logic [BYTE_W-1:0] OP_REST_LO       = 8'hC0;
  localparam logic [BYTE_W-1:0] OP_SPEED_LO      = 8'hD0;
  localparam logic [BYTE_W-1:0] OP_CMD_LO        = 8'hE0;
  localparam logic [BYTE_W-1:0] OP_EARLY_OCT_HI  = 8'hE7;
  localparam logic [BYTE_W-1:0] OP_LATE_OCT_HI   = 8'hD7;
  localparam logic [BYTE_W-1:0] OP_LATE_GRP_LO   = 8'hF1;
  localparam logic [BYTE_W-1:0] OP_LATE_GRP_HI   = 8'hF9;

  // command lengths
  localparam logic [LEN_W-1:0] LEN1 = 3'd1;
  localparam logic [LEN_W-1:0] LEN2 = 3'd2;
  localparam logic [LEN_W-1:0] LEN3 = 3'd3;
  localparam logic [LEN_W-1:0] LEN4 = 3'd4;

  // command kind codes
  localparam logic [KIND_W-1:0] K_NOTE             = 6'd0;
  localparam logic [KIND_W-1:0] K_DRUM_NOTE        = 6'd1;
  localparam logic [KIND_W-1:0] K_REST             = 6'd2;
  localparam logic [KIND_W-1:0] K_NOTE_TYPE        = 6'd3;
  localparam logic [KIND_W-1:0] K_DRUM_SPEED       = 6'd4;
  localparam logic [KIND_W-1:0] K_OCTAVE           = 6'd5;
  localparam logic [KIND_W-1:0] K_PERFECT_PITCH    = 6'd6;
  localparam logic [KIND_W-1:0] K_INVALID_E9       = 6'd7;
  localparam logic [KIND_W-1:0] K_VIBRATO          = 6'd8;
  localparam logic [KIND_W-1:0] K_PITCH_SLIDE      = 6'd9;
  localparam logic [KIND_W-1:0] K_DUTY             = 6'd10;
  localparam logic [KIND_W-1:0] K_TEMPO            = 6'd11;
  localparam logic [KIND_W-1:0] K_PAN_EARLY        = 6'd12;
  localparam logic [KIND_W-1:0] K_CMD_EF           = 6'd13;
  localparam logic [KIND_W-1:0] K_MASTER_VOL       = 6'd14;
  localparam logic [KIND_W-1:0] K_SILENT_DRUM      = 6'd15;
  localparam logic [KIND_W-1:0] K_SFX_MUSIC        = 6'd16;
  localparam logic [KIND_W-1:0] K_DUTY_PATTERN     = 6'd17;
  localparam logic [KIND_W-1:0] K_CALL             = 6'd18;
  localparam logic [KIND_W-1:0] K_LOOP_FOREVER     = 6'd19;
  localparam logic [KIND_W-1:0] K_LOOP_COUNT       = 6'd20;
  localparam logic [KIND_W-1:0] K_END              = 6'd21;
  localparam logic [KIND_W-1:0] K_UNKNOWN          = 6'd22;
  localparam logic [KIND_W-1:0] K_DRUM_SPEED_INSTR = 6'd23;
  localparam logic [KIND_W-1:0] K_TRANSPOSE        = 6'd24;
  localparam logic [KIND_W-1:0] K_VOL_ENV          = 6'd25;
  localparam logic [KIND_W-1:0] K_PITCH_SWEEP      = 6'd26;
  localparam logic [KIND_W-1:0] K_CMD_E2           = 6'd27;
  localparam logic [KIND_W-1:0] K_NOISE            = 6'd28;
  localparam logic [KIND_W-1:0] K_STEREO_PAN       = 6'd29;
  localparam logic [KIND_W-1:0] K_PITCH_OFFSET     = 6'd30;
  localparam logic [KIND_W-1:0] K_CMD_E7           = 6'd31;
  localparam logic [KIND_W-1:0] K_CMD_E8           = 6'd32;
  localparam logic [KIND_W-1:0] K_REL_TEMPO        = 6'd33;
  localparam logic [KIND_W-1:0] K_RESTART          = 6'd34;
  localparam logic [KIND_W-1:0] K_NEW_SONG         = 6'd35;
  localparam logic [KIND_W-1:0] K_PRIO_ON          = 6'd36;
  localparam logic [KIND_W-1:0] K_PRIO_OFF         = 6'd37;
  localparam logic [KIND_W-1:0] K_CMD_EE           = 6'd38;
  localparam logic [KIND_W-1:0] K_PAN_LATE         = 6'd39;
  localparam logic [KIND_W-1:0] K_TOGGLE_NOISE     = 6'd40;
  localparam logic [KIND_W-1:0] K_CMD_F1_F9        = 6'd41;
  localparam logic [KIND_W-1:0] K_SET_COND         = 6'd42;
  localparam logic [KIND_W-1:0] K_COND_JUMP        = 6'd43;
  localparam logic [KIND_W-1:0] K_JUMP             = 6'd44;

  // how the nibble and word fields are drawn from the command bytes
  typedef enum logic [3:0] {
    FLD_NONE     = 4'd0,
    FLD_OPNIB    = 4'd1,
    FLD_OPLOW    = 4'd2,
    FLD_DRUMNOTE = 4'd3,
    FLD_P1NIB    = 4'd4,
    FLD_P2NIB    = 4'd5,
    FLD_BE12     = 4'd6,
    FLD_LE12     = 4'd7,
    FLD_LE23     = 4'd8
  } fld_mode_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [LEN_W-1:0]  len;
    fld_mode_t         mode;
  } cmd_class_t;

  // gathered command, bytes past the length are zero
  typedef struct packed {
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic [BYTE_W-1:0] b3;
    logic [LEN_W-1:0]  n;
    logic              drum;
  } cmd_rec_t;

  function automatic cmd_class_t mk(logic [KIND_W-1:0] k, logic [LEN_W-1:0] l,
                                    fld_mode_t m);
    cmd_class_t c;
    c.kind = k;
    c.len  = l;
    c.mode = m;
    return c;
  endfunction

  function automatic cmd_class_t classify_early(logic [BYTE_W-1:0] op, logic drum);
    cmd_class_t c;
    if (op < OP_REST_LO) begin
      c = drum ? mk(K_DRUM_NOTE, LEN2, FLD_DRUMNOTE) : mk(K_NOTE, LEN1, FLD_OPNIB);
    end else if (op < OP_SPEED_LO) begin
      c = mk(K_REST, LEN1, FLD_OPLOW);
    end else if (op < OP_CMD_LO) begin
      c = drum ? mk(K_DRUM_SPEED, LEN1, FLD_OPLOW) : mk(K_NOTE_TYPE, LEN2, FLD_P1NIB);
    end else if (op <= OP_EARLY_OCT_HI) begin
      c = mk(K_OCTAVE, LEN1, FLD_OPLOW);
    end else begin
      case (op)
        8'hE8:   c = mk(K_PERFECT_PITCH, LEN1, FLD_NONE);
        8'hE9:   c = mk(K_INVALID_E9, LEN1, FLD_NONE);
        8'hEA:   c = mk(K_VIBRATO, LEN3, FLD_P2NIB);
        8'hEB:   c = mk(K_PITCH_SLIDE, LEN3, FLD_P2NIB);
        8'hEC:   c = mk(K_DUTY, LEN2, FLD_NONE);
        8'hED:   c = mk(K_TEMPO, LEN3, FLD_BE12);
        8'hEE:   c = mk(K_PAN_EARLY, LEN2, FLD_NONE);
        8'hEF:   c = mk(K_CMD_EF, LEN1, FLD_NONE);
        8'hF0:   c = mk(K_MASTER_VOL, LEN2, FLD_P1NIB);
        8'hF1:   c = mk(K_SILENT_DRUM, LEN1, FLD_NONE);
        8'hF8:   c = mk(K_SFX_MUSIC, LEN1, FLD_NONE);
        8'hFC:   c = mk(K_DUTY_PATTERN, LEN2, FLD_NONE);
        8'hFD:   c = mk(K_CALL, LEN3, FLD_LE12);
        8'hFE:   c = mk(K_LOOP_COUNT, LEN4, FLD_LE23);
        8'hFF:   c = mk(K_END, LEN1, FLD_NONE);
        default: c = mk(K_UNKNOWN, LEN1, FLD_NONE);
      endcase
    end
    return c;
  endfunction

  function automatic cmd_class_t classify_late(logic [BYTE_W-1:0] op, logic drum);
    cmd_class_t c;
    if (op < OP_LATE_NOTE_LO) begin
      c = mk(K_REST, LEN1, FLD_OPLOW);
    end else if (op < OP_SPEED_LO) begin
      c = mk(K_NOTE, LEN1, FLD_OPNIB);
    end else if (op < OP_CMD_LO && drum) begin
      c = mk(K_DRUM_SPEED_INSTR, LEN2, FLD_OPLOW);
    end else if (op <= OP_LATE_OCT_HI) begin
      c = mk(K_OCTAVE, LEN1, FLD_OPLOW);
    end else if (op >= OP_LATE_GRP_LO && op <= OP_LATE_GRP_HI) begin
      c = mk(K_CMD_F1_F9, LEN1, FLD_NONE);
    end else begin
      case (op)
        8'hD8:   c = mk(K_NOTE_TYPE, LEN3, FLD_P2NIB);
        8'hD9:   c = mk(K_TRANSPOSE, LEN2, FLD_P1NIB);
        8'hDA:   c = mk(K_TEMPO, LEN3, FLD_BE12);
        8'hDB:   c = mk(K_DUTY, LEN2, FLD_NONE);
        8'hDC:   c = mk(K_VOL_ENV, LEN2, FLD_P1NIB);
        8'hDD:   c = mk(K_PITCH_SWEEP, LEN2, FLD_NONE);
        8'hDE:   c = mk(K_DUTY_PATTERN, LEN2, FLD_NONE);
        8'hDF:   c = mk(K_SFX_MUSIC, LEN1, FLD_NONE);
        8'hE0:   c = mk(K_PITCH_SLIDE, LEN3, FLD_P2NIB);
        8'hE1:   c = mk(K_VIBRATO, LEN3, FLD_P2NIB);
        8'hE2:   c = mk(K_CMD_E2, LEN2, FLD_NONE);
        8'hE3:   c = mk(K_NOISE, LEN2, FLD_NONE);
        8'hE4:   c = mk(K_STEREO_PAN, LEN2, FLD_P1NIB);
        8'hE5:   c = mk(K_MASTER_VOL, LEN2, FLD_P1NIB);
        8'hE6:   c = mk(K_PITCH_OFFSET, LEN3, FLD_BE12);
        8'hE7:   c = mk(K_CMD_E7, LEN2, FLD_NONE);
        8'hE8:   c = mk(K_CMD_E8, LEN2, FLD_NONE);
        8'hE9:   c = mk(K_REL_TEMPO, LEN2, FLD_NONE);
        8'hEA:   c = mk(K_RESTART, LEN3, FLD_LE12);
        8'hEB:   c = mk(K_NEW_SONG, LEN3, FLD_LE12);
        8'hEC:   c = mk(K_PRIO_ON, LEN1, FLD_NONE);
        8'hED:   c = mk(K_PRIO_OFF, LEN1, FLD_NONE);
        8'hEE:   c = mk(K_CMD_EE, LEN3, FLD_LE12);
        8'hEF:   c = mk(K_PAN_LATE, LEN2, FLD_P1NIB);
        8'hF0:   c = mk(K_TOGGLE_NOISE, LEN1, FLD_NONE);
        8'hFA:   c = mk(K_SET_COND, LEN2, FLD_NONE);
        8'hFB:   c = mk(K_COND_JUMP, LEN4, FLD_LE23);
        8'hFC:   c = mk(K_JUMP, LEN3, FLD_LE12);
        8'hFD:   c = mk(K_LOOP_COUNT, LEN4, FLD_LE23);
        8'hFE:   c = mk(K_CALL, LEN3, FLD_LE12);
        default: c = mk(K_END, LEN1, FLD_NONE);
      endcase
    end
    return c;
  endfunction

  function automatic cmd_class_t classify(logic [BYTE_W-1:0] op, logic drum, logic fmt);
    cmd_class_t c;
    c = fmt ? classify_late(op, drum) : classify_early(op, drum);
    return c;
  endfunction

  // a counted loop with a zero count loops forever and ends the track
  function automatic logic [KIND_W-1:0] final_kind(cmd_class_t c, logic [BYTE_W-1:0] b1);
    logic [KIND_W-1:0] k;
    k = c.kind;
    if (c.kind == K_LOOP_COUNT && b1 == '0) begin
      k = K_LOOP_FOREVER;
    end
    return k;
  endfunction

endpackage

// ===== sv/mscd_in_if.sv =====
// mscd_in_if: valid/ready channel carrying one sequence byte per transaction.
// Depends on mscd_pkg for field widths.
interface mscd_in_if;
  logic                        valid;
  logic                        ready;
  logic [mscd_pkg::BYTE_W-1:0] data_byte;
  logic [mscd_pkg::CHAN_W-1:0] channel_index;
  logic                        track_start;

  modport source (output valid, data_byte, channel_index, track_start, input ready);
  modport sink   (input valid, data_byte, channel_index, track_start, output ready);
endinterface

// ===== sv/mscd_out_if.sv =====
// mscd_out_if: valid/ready channel carrying one decoded command record per
// transaction. Depends on mscd_pkg for field widths.
interface mscd_out_if;
  logic                        valid;
  logic                        ready;
  logic [mscd_pkg::KIND_W-1:0] command_kind;
  logic [mscd_pkg::BYTE_W-1:0] opcode_byte;
  logic [mscd_pkg::BYTE_W-1:0] param_byte;
  logic [mscd_pkg::NIB_W-1:0]  upper_nibble;
  logic [mscd_pkg::NIB_W-1:0]  lower_nibble;
  logic [mscd_pkg::WORD_W-1:0] word_value;
  logic [mscd_pkg::LEN_W-1:0]  command_length;
  logic                        track_end;

  modport source (output valid, command_kind, opcode_byte, param_byte, upper_nibble,
                  lower_nibble, word_value, command_length, track_end, input ready);
  modport sink   (input valid, command_kind, opcode_byte, param_byte, upper_nibble,
                  lower_nibble, word_value, command_length, track_end, output ready);
endinterface

// ===== sv/mscd_gather.sv =====
// mscd_gather: collects the bytes of one command and registers the complete
// command record. Depends on mscd_pkg (classify, cmd_rec_t).
module mscd_gather (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fmt,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mscd_pkg::BYTE_W-1:0] in_byte,
  input  logic [mscd_pkg::CHAN_W-1:0] in_chan,
  input  logic                        in_start,
  input  logic                        dn_ready,
  output logic                        rec_vld,
  output mscd_pkg::cmd_rec_t          rec
);
  import mscd_pkg::*;

  logic [1:0]        held_r, held_nxt;
  logic [LEN_W-1:0]  need_r, need_nxt;
  logic              done_r, done_nxt;
  logic [BYTE_W-1:0] hb_r [3];
  logic              rec_vld_r, rec_vld_nxt;
  cmd_rec_t          rec_r;

  logic       acc;
  logic [1:0] held_eff;
  logic [LEN_W-1:0] need_eff;
  logic       done_eff;
  logic       emit;
  logic       store;
  cmd_rec_t   cur;
  cmd_class_t cls;

  assign in_ready = !rec_vld_r || dn_ready;
  assign acc      = in_valid && in_ready;

  // record as it would stand if this byte completes the command
  always_comb begin
    held_eff = in_start ? 2'd0 : held_r;
    need_eff = in_start ? '0 : need_r;
    done_eff = in_start ? 1'b0 : done_r;

    cur.drum = (in_chan == DRUM_CHAN);
    cur.n    = {1'b0, held_eff} + LEN1;
    cur.b0   = (held_eff == 2'd0) ? in_byte : hb_r[0];
    cur.b1   = (held_eff == 2'd1) ? in_byte : (held_eff >= 2'd2) ? hb_r[1] : '0;
    cur.b2   = (held_eff == 2'd2) ? in_byte : (held_eff == 2'd3) ? hb_r[2] : '0;
    cur.b3   = (held_eff == 2'd3) ? in_byte : '0;

    cls = classify(cur.b0, cur.drum, fmt);

    held_nxt = held_eff;
    need_nxt = need_eff;
    done_nxt = done_eff;
    emit     = 1'b0;
    store    = 1'b0;
    if (!done_eff) begin
      if (held_eff == 2'd0) begin
        if (cls.len <= LEN1) begin
          emit = 1'b1;
        end else begin
          store    = 1'b1;
          held_nxt = 2'd1;
          need_nxt = cls.len;
        end
      end else if (({1'b0, held_eff} + LEN1) < need_eff && held_eff < 2'd3) begin
        store    = 1'b1;
        held_nxt = held_eff + 2'd1;
      end else begin
        emit     = 1'b1;
        held_nxt = 2'd0;
        need_nxt = '0;
      end
    end
    if (emit) begin
      done_nxt = (final_kind(cls, cur.b1) == K_END) ||
                 (final_kind(cls, cur.b1) == K_LOOP_FOREVER);
    end

    rec_vld_nxt = in_ready ? (acc && emit) : rec_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r    <= 2'd0;
      need_r    <= '0;
      done_r    <= 1'b0;
      rec_vld_r <= 1'b0;
    end else begin
      rec_vld_r <= rec_vld_nxt;
      if (acc) begin
        held_r <= held_nxt;
        need_r <= need_nxt;
        done_r <= done_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && store) begin
      hb_r[held_eff] <= in_byte;
    end
    if (acc && emit) begin
      rec_r <= cur;
    end
  end

  assign rec_vld = rec_vld_r;
  assign rec     = rec_r;

endmodule

// ===== sv/mscd_decode.sv =====
// mscd_decode: turns a gathered command record into the result fields and
// holds them in the output register. Depends on mscd_pkg.
module mscd_decode (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fmt,
  input  logic               rec_vld,
  input  mscd_pkg::cmd_rec_t rec,
  output logic               dn_ready,
  mscd_out_if.source         out_ch
);
  import mscd_pkg::*;

  cmd_class_t        cls;
  logic [KIND_W-1:0] kind;
  logic [NIB_W-1:0]  up, lo;
  logic [WORD_W-1:0] word;
  logic              tend;

  logic              out_vld_r;
  logic [KIND_W-1:0] kind_r;
  logic [BYTE_W-1:0] op_r, par_r;
  logic [NIB_W-1:0]  up_r, lo_r;
  logic [WORD_W-1:0] word_r;
  logic [LEN_W-1:0]  len_r;
  logic              end_r;

  assign dn_ready = !out_vld_r || out_ch.ready;

  always_comb begin
    cls  = classify(rec.b0, rec.drum, fmt);
    up   = '0;
    lo   = '0;
    word = '0;
    case (cls.mode)
      FLD_OPNIB: begin
        up = rec.b0[7:4];
        lo = rec.b0[3:0];
      end
      FLD_OPLOW:    lo = rec.b0[3:0];
      FLD_DRUMNOTE: up = rec.b0[3:0];
      FLD_P1NIB: begin
        up = rec.b1[7:4];
        lo = rec.b1[3:0];
      end
      FLD_P2NIB: begin
        up = rec.b2[7:4];
        lo = rec.b2[3:0];
      end
      FLD_BE12: word = {rec.b1, rec.b2};
      FLD_LE12: word = {rec.b2, rec.b1};
      FLD_LE23: word = {rec.b3, rec.b2};
      default: ;
    endcase
    kind = final_kind(cls, rec.b1);
    tend = (kind == K_END) || (kind == K_LOOP_FOREVER);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (dn_ready) begin
      out_vld_r <= rec_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (dn_ready && rec_vld) begin
      kind_r <= kind;
      op_r   <= rec.b0;
      par_r  <= rec.b1;
      up_r   <= up;
      lo_r   <= lo;
      word_r <= word;
      len_r  <= rec.n;
      end_r  <= tend;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.command_kind   = kind_r;
  assign out_ch.opcode_byte    = op_r;
  assign out_ch.param_byte     = par_r;
  assign out_ch.upper_nibble   = up_r;
  assign out_ch.lower_nibble   = lo_r;
  assign out_ch.word_value     = word_r;
  assign out_ch.command_length = len_r;
  assign out_ch.track_end      = end_r;

endmodule

// ===== sv/music_sequence_command_decoder_core.sv =====
// Sequence command decoder, top level.
// in_ch carries one sequence byte per transaction with its channel number
// (3 is the drum channel) and a track start flag that clears the parser
// before the byte is taken. out_ch carries one decoded record per complete
// command: kind, opcode, parameter byte, nibble pair, 16-bit word, length
// and an end flag. cfg_wr_en/cfg_wr_data set the table format (0 early,
// 1 later); write it only while no command is in flight.
// Throughput: one byte per cycle while in_ch.ready is high. The last byte of
// a command reaches out_ch through the gather register, then the output
// register; bytes that do not complete a command give no record.
// After an end command or a zero-count loop, bytes are swallowed until the
// next byte marked as track start.
// Reset clears the gather state, both valid flags and the format bit.
// When out_ch stalls the output register holds; the gather register takes
// one more record, after which in_ch.ready drops until the output is taken.
// Depends on mscd_pkg, mscd_in_if, mscd_out_if, mscd_gather, mscd_decode.
module music_sequence_command_decoder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  mscd_in_if.sink    in_ch,
  mscd_out_if.source out_ch
);
  import mscd_pkg::*;

  logic     fmt_r;
  logic     dn_ready;
  logic     rec_vld;
  cmd_rec_t rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= 1'b0;
    end else if (cfg_wr_en) begin
      fmt_r <= cfg_wr_data;
    end
  end

  mscd_gather u_gather (
    .clk      (clk),
    .rst_n    (rst_n),
    .fmt      (fmt_r),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_byte  (in_ch.data_byte),
    .in_chan  (in_ch.channel_index),
    .in_start (in_ch.track_start),
    .dn_ready (dn_ready),
    .rec_vld  (rec_vld),
    .rec      (rec)
  );

  mscd_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .fmt      (fmt_r),
    .rec_vld  (rec_vld),
    .rec      (rec),
    .dn_ready (dn_ready),
    .out_ch   (out_ch)
  );

  // end flag only on end or endless loop records
  a_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.track_end |->
      (out_ch.command_kind == K_END || out_ch.command_kind == K_LOOP_FOREVER))
    else $error("track_end on a non-ending command");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.command_length != '0 && out_ch.command_length <= LEN4))
    else $error("command_length out of range");

  // a gathered record is never dropped while the output stage is busy
  a_rec_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rec_vld && !dn_ready |=> rec_vld && $stable(rec))
    else $error("gathered record lost under stall");

  a_no_accept_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    rec_vld && !dn_ready |-> !in_ch.ready)
    else $error("input accepted while both stages full");

endmodule
